// File: rtl/core/ipra_pkg.sv
// Shared types, constants and helpers for the I/O port range allocator.
`default_nettype none

package ipra_pkg;

    localparam int MAX_RANGES = 64;
    localparam int IDX_W      = $clog2(MAX_RANGES);
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);
    localparam int SIZE_W     = 16;
    localparam int CAND_W     = SIZE_W + 1;
    localparam int END_W      = SIZE_W + 2;
    localparam int ENTRY_W    = 2 * SIZE_W;
    localparam int RSV_N      = 9;

    localparam logic [END_W-1:0] PORT_SPACE = END_W'(32'h0001_0000);

    // Legacy reserved windows, half-open [lo, hi)
    localparam logic [END_W-1:0] RSV_LO [RSV_N] = '{
        18'h00000, 18'h00100, 18'h001F0, 18'h00170, 18'h00200,
        18'h003B0, 18'h00378, 18'h003F0, 18'h00CF8
    };
    localparam logic [END_W-1:0] RSV_HI [RSV_N] = '{
        18'h00100, 18'h00200, 18'h001F8, 18'h00178, 18'h00210,
        18'h003E0, 18'h00380, 18'h003F8, 18'h00D00
    };

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_NOFREE = 2'd2,
        ST_ZERO   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASSIFY,
        S_TRY,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic    load;       // capture size, seed candidate
        logic    next_cand;  // advance candidate by size, restart scan
        logic    rd;         // read table entry at scan index, advance index
        logic    store;      // write {size, base} at fill count
        logic    set_res;    // latch result code and base
        logic    res_cand;   // result base is the candidate (else zero)
        status_t res_code;
        logic    load_out;   // move result into the output register
    } ipra_cmd_t;

    typedef struct packed {
        logic size_zero;
        logic full;
        logic empty;
        logic fits;
        logic rsv_hit;
        logic scan_done;
        logic overlap;
        logic out_free;
    } ipra_sts_t;

    // True when the start or the end of [base, stop) lands in a reserved window
    function automatic logic rsv_touch(input logic [END_W-1:0] base,
                                       input logic [END_W-1:0] stop);
        logic hit;
        hit = 1'b0;
        for (int r = 0; r < RSV_N; r++)
        begin
            if (base >= RSV_LO[r] && base < RSV_HI[r])
                hit = 1'b1;
            if (stop > RSV_LO[r] && stop <= RSV_HI[r])
                hit = 1'b1;
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/ipra_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none

module ipra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// File: rtl/core/ipra_ctrl.sv
// Allocation sequencer: walks candidates and drives the datapath.
`default_nettype none

module ipra_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire ipra_pkg::ipra_sts_t sts,
    output ipra_pkg::ipra_cmd_t      cmd
);

    ipra_pkg::state_t state_reg;
    ipra_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ipra_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ipra_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = ipra_pkg::S_CLASSIFY;
            end
            ipra_pkg::S_CLASSIFY:
            begin
                if (sts.size_zero || sts.full || sts.empty)
                    state_next = ipra_pkg::S_DONE;
                else
                    state_next = ipra_pkg::S_TRY;
            end
            ipra_pkg::S_TRY:
            begin
                if (!sts.fits)
                    state_next = ipra_pkg::S_DONE;
                else if (!sts.rsv_hit)
                    state_next = ipra_pkg::S_SCAN;
            end
            ipra_pkg::S_SCAN:
            begin
                if (sts.overlap)
                    state_next = ipra_pkg::S_TRY;
                else if (sts.scan_done)
                    state_next = ipra_pkg::S_DONE;
            end
            ipra_pkg::S_DONE:
            begin
                if (sts.out_free)
                    state_next = ipra_pkg::S_IDLE;
            end
            default: state_next = ipra_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.res_code = ipra_pkg::ST_OK;
        in_ready     = 1'b0;
        unique case (state_reg)
            ipra_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ipra_pkg::S_CLASSIFY:
            begin
                if (sts.size_zero)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ipra_pkg::ST_ZERO;
                end
                else if (sts.full)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ipra_pkg::ST_FULL;
                end
                else if (sts.empty)
                begin
                    // first grant goes to base zero unchecked
                    cmd.store   = 1'b1;
                    cmd.set_res = 1'b1;
                end
            end
            ipra_pkg::S_TRY:
            begin
                if (!sts.fits)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ipra_pkg::ST_NOFREE;
                end
                else if (sts.rsv_hit)
                    cmd.next_cand = 1'b1;
                else
                    cmd.rd = 1'b1;
            end
            ipra_pkg::S_SCAN:
            begin
                if (sts.overlap)
                    cmd.next_cand = 1'b1;
                else if (sts.scan_done)
                begin
                    cmd.store    = 1'b1;
                    cmd.set_res  = 1'b1;
                    cmd.res_cand = 1'b1;
                end
                else
                    cmd.rd = 1'b1;
            end
            ipra_pkg::S_DONE:
            begin
                cmd.load_out = sts.out_free;
            end
            default: cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/ipra_dp.sv
// Candidate, scan and result datapath with the range table.
`default_nettype none

module ipra_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [ipra_pkg::SIZE_W-1:0]   in_size,
    input  wire ipra_pkg::ipra_cmd_t           cmd,
    output ipra_pkg::ipra_sts_t                sts,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [ipra_pkg::SIZE_W-1:0]        out_base,
    output logic [1:0]                         out_status
);

    logic [ipra_pkg::SIZE_W-1:0]  size_reg;
    logic [ipra_pkg::CAND_W-1:0]  cand_reg;
    logic [ipra_pkg::CNT_W-1:0]   idx_reg;
    logic [ipra_pkg::CNT_W-1:0]   count_reg;
    logic [ipra_pkg::SIZE_W-1:0]  res_base_reg;
    ipra_pkg::status_t            res_code_reg;
    logic                         out_valid_reg;
    logic [ipra_pkg::SIZE_W-1:0]  out_base_reg;
    ipra_pkg::status_t            out_code_reg;

    logic [ipra_pkg::END_W-1:0]   cand_end;
    logic [ipra_pkg::END_W-1:0]   cand_ext;
    logic [ipra_pkg::SIZE_W-1:0]  wr_base;
    logic [ipra_pkg::IDX_W-1:0]   ram_addr;
    logic [ipra_pkg::ENTRY_W-1:0] ram_wdata;
    logic [ipra_pkg::ENTRY_W-1:0] ram_rdata;
    logic [ipra_pkg::SIZE_W-1:0]  ent_start;
    logic [ipra_pkg::CAND_W-1:0]  ent_stop;

    assign cand_ext = {1'b0, cand_reg};
    assign cand_end = cand_ext + {2'b00, size_reg};

    assign wr_base   = cmd.res_cand ? cand_reg[ipra_pkg::SIZE_W-1:0] : '0;
    assign ram_wdata = {size_reg, wr_base};
    assign ram_addr  = cmd.store ? count_reg[ipra_pkg::IDX_W-1:0]
                                 : idx_reg[ipra_pkg::IDX_W-1:0];

    ipra_ram #(
        .WIDTH (ipra_pkg::ENTRY_W),
        .DEPTH (ipra_pkg::MAX_RANGES)
    ) u_table (
        .clk   (clk),
        .we    (cmd.store),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign ent_start = ram_rdata[ipra_pkg::SIZE_W-1:0];
    assign ent_stop  = {1'b0, ent_start}
                     + {1'b0, ram_rdata[ipra_pkg::ENTRY_W-1:ipra_pkg::SIZE_W]};

    always_comb
    begin
        sts.size_zero = (size_reg == '0);
        sts.full      = (count_reg >= ipra_pkg::CNT_W'(ipra_pkg::MAX_RANGES));
        sts.empty     = (count_reg == '0);
        sts.fits      = (cand_end <= ipra_pkg::PORT_SPACE);
        sts.rsv_hit   = ipra_pkg::rsv_touch(cand_ext, cand_end);
        sts.scan_done = (idx_reg == count_reg);
        // nonempty half-open ranges intersect
        sts.overlap   = (cand_reg < ent_stop) && ({2'b00, ent_start} < cand_end);
        sts.out_free  = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            size_reg <= in_size;
            cand_reg <= {1'b0, in_size};
        end
        else if (cmd.next_cand)
            cand_reg <= cand_end[ipra_pkg::CAND_W-1:0];
        if (cmd.set_res)
        begin
            res_code_reg <= cmd.res_code;
            res_base_reg <= wr_base;
        end
        if (cmd.load_out)
        begin
            out_base_reg <= res_base_reg;
            out_code_reg <= res_code_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load || cmd.next_cand)
                idx_reg <= '0;
            else if (cmd.rd)
                idx_reg <= idx_reg + 1'b1;
            if (cmd.store)
                count_reg <= count_reg + 1'b1;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_base   = out_base_reg;
    assign out_status = out_code_reg;

    a_store_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> !sts.full)
        else $error("table write with full table");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ipra_pkg::CNT_W'(ipra_pkg::MAX_RANGES))
        else $error("fill count beyond table depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |=> count_reg == $past(count_reg) + 1'b1)
        else $error("fill count did not advance on store");

    a_fail_base_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_code_reg != ipra_pkg::ST_OK) |-> out_base_reg == '0)
        else $error("failed request returned nonzero base");

    a_scan_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |-> idx_reg < count_reg)
        else $error("scan read past fill count");

endmodule

`default_nettype wire

// File: rtl/core/io_port_range_allocator.sv
// Top level of the I/O port range allocator.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata[15:0] range_size
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata[15:0] range_base,
//                                                tuser[1:0] status
//
// One request is handled at a time. Zero size, full table and the first
// grant are settled in the classify state, with no candidate search.
// Otherwise candidate bases are tried in turn: one that hits a reserved
// window is skipped, one past the port space fails the request; the rest
// are scanned against the table (one entry per cycle off the table RAM's
// registered read port); a scan stops at the first overlapping entry.
// Reset clears the fill count and the sequencer; table contents are not
// cleared, only entries below the fill count are read, so no clearing pass.
// A result held by a stalled m_axis side blocks only the next result: the
// next word is accepted and worked on while the held result waits.
`default_nettype none

module io_port_range_allocator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] range_size
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] range_base
    output logic [1:0]       m_axis_tuser    // [1:0] status
);

    ipra_pkg::ipra_cmd_t cmd;
    ipra_pkg::ipra_sts_t sts;

    // sequencer: accepts a word in idle, then walks the candidates
    ipra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: candidate arithmetic, reserved-window check, table, result
    ipra_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_size    (s_axis_tdata),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_base   (m_axis_tdata),
        .out_status (m_axis_tuser)
    );

endmodule

`default_nettype wire

// File: dv/ipra_checker.sv
// Scoreboard for the I/O port range allocator: predicts every grant and checks the result stream.
module ipra_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] range_size
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // [15:0] range_base
    input  logic [1:0]  m_axis_tuser,   // [1:0] status
    output int          failures,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [17:0] SPACE_END = 18'h10000;
    localparam int          N_LEGACY  = 9;
    localparam logic [17:0] LEGACY_LO [N_LEGACY] = '{
        18'h00000, 18'h00100, 18'h001F0, 18'h00170, 18'h00200,
        18'h003B0, 18'h00378, 18'h003F0, 18'h00CF8
    };
    localparam logic [17:0] LEGACY_HI [N_LEGACY] = '{
        18'h00100, 18'h00200, 18'h001F8, 18'h00178, 18'h00210,
        18'h003E0, 18'h00380, 18'h003F8, 18'h00D00
    };

    typedef struct packed {
        logic [15:0]       base;
        ipra_pkg::status_t code;
    } grant_t;

    logic [15:0]                tbl_base [ipra_pkg::MAX_RANGES];
    logic [15:0]                tbl_len  [ipra_pkg::MAX_RANGES];
    logic [ipra_pkg::CNT_W-1:0] tbl_fill;
    grant_t                     grants_due [$];

    // start or end of [lo, hi) lands inside a legacy window
    function automatic logic hits_legacy(input logic [17:0] lo, input logic [17:0] hi);
        for (int r = 0; r < N_LEGACY; r++)
        begin
            if ((lo >= LEGACY_LO[r] && lo < LEGACY_HI[r]) ||
                (hi > LEGACY_LO[r] && hi <= LEGACY_HI[r]))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic hits_table(input logic [17:0] lo, input logic [17:0] hi);
        logic [17:0] s;
        logic [17:0] e;
        for (int i = 0; i < tbl_fill; i++)
        begin
            s = {2'b00, tbl_base[i]};
            e = s + {2'b00, tbl_len[i]};
            if ((lo >= s && lo < e) || (hi > s && hi <= e) || (lo <= s && hi >= e))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Work out the grant for one request and record it in the table copy
    function automatic grant_t allocate_range(input logic [15:0] sz);
        grant_t      g;
        logic [17:0] cand;
        g.base = '0;
        g.code = ipra_pkg::ST_OK;
        if (sz == 16'd0)
        begin
            g.code = ipra_pkg::ST_ZERO;
            return g;
        end
        if (tbl_fill >= ipra_pkg::MAX_RANGES)
        begin
            g.code = ipra_pkg::ST_FULL;
            return g;
        end
        if (tbl_fill != '0)
        begin
            g.code = ipra_pkg::ST_NOFREE;
            cand   = {2'b00, sz};
            while (g.code == ipra_pkg::ST_NOFREE && cand + {2'b00, sz} <= SPACE_END)
            begin
                if (!hits_legacy(cand, cand + {2'b00, sz}) &&
                    !hits_table(cand, cand + {2'b00, sz}))
                begin
                    g.code = ipra_pkg::ST_OK;
                    g.base = cand[15:0];
                end
                else
                    cand = cand + {2'b00, sz};
            end
        end
        if (g.code == ipra_pkg::ST_OK)
        begin
            tbl_base[tbl_fill] = g.base;
            tbl_len[tbl_fill]  = sz;
            tbl_fill           = tbl_fill + 1'b1;
        end
        return g;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t: mismatch on %s: got 0x%04h, want 0x%04h", $time, what, got, want);
        failures++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grant_t due;
        if (!rst_n)
        begin
            tbl_fill = '0;
            grants_due.delete();
            outstanding <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (grants_due.size() == 0)
                    report_mismatch("unrequested result word", m_axis_tdata, 16'h0000);
                else
                begin
                    due = grants_due.pop_front();
                    if (m_axis_tdata !== due.base)
                        report_mismatch("range_base", m_axis_tdata, due.base);
                    if (m_axis_tuser !== due.code)
                        report_mismatch("status", {14'd0, m_axis_tuser}, {14'd0, due.code});
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                grants_due.push_back(allocate_range(s_axis_tdata));
            outstanding <= grants_due.size();
        end
    end

endmodule

// File: dv/tb_top.sv
// Top of the range allocator testbench: clock, reset, request stimulus and the verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // A size-4 request against a crowded table can scan thousands of
    // candidates, each against up to every entry, so allow a long quiet stretch.
    localparam int STALL_LIMIT  = 4_000_000;
    localparam int RANDOM_WORDS = 700;
    localparam int CALM_TAIL    = 100;
    localparam int DRAIN_CYCLES = 300;

    // Directed sizes: zero on an empty table, the unchecked first grant,
    // a size that cannot fit at all, the upper half taken and refused,
    // ranges that enclose legacy windows, small fills next to them,
    // alternating bit patterns and a final zero with a populated table.
    localparam int          N_DIRECTED = 18;
    localparam logic [15:0] DIRECTED_SIZES [N_DIRECTED] = '{
        16'h0000, 16'h0001, 16'hFFFF, 16'h8000, 16'h8000, 16'h0001,
        16'h0100, 16'h0010, 16'h0008, 16'h0002, 16'h0003, 16'h0178,
        16'h0050, 16'h00F8, 16'h5555, 16'hAAAA, 16'h7FFF, 16'h0000
    };

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;    // [15:0] range_size
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [15:0] range_base
    logic [1:0]  m_axis_tuser;          // [1:0] status

    int   failures;
    int   outstanding;
    logic gaps_on   = 1'b1;
    int   hold_left = 0;
    int   idle_run;

    io_port_range_allocator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    ipra_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .failures      (failures),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Result side: drop tready in random bursts while gaps are on.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= $urandom_range(0, 7);
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Watchdog: give up once no word has moved on either side for too long.
    initial
    begin
        idle_run = 0;
        while (idle_run < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Offer one request word and hold it until accepted; then maybe pause.
    // tready is sampled right after the edge, so it is the value the DUT saw.
    task automatic send_size(input logic [15:0] sz);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sz;
        do @(posedge clk); while (!s_axis_tready);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // Stop offering words and hold until every grant has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    initial
    begin
        int          roll;
        logic [15:0] sz;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_SIZES[k])
            send_size(DIRECTED_SIZES[k]);
        drain_results();

        // Random sizes: mostly small so the table fills through many scans,
        // some medium and large ones, and a few zero sizes. Once the table
        // is full every nonzero request must come back as table full.
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == 200)
                gaps_on <= 1'b0;
            if (n == 260)
                gaps_on <= 1'b1;
            if (n == RANDOM_WORDS - CALM_TAIL)
                gaps_on <= 1'b0;
            if (n == 350)
                drain_results();
            roll = $urandom_range(0, 99);
            if (roll < 6)
                sz = 16'h0000;
            else if (roll < 14)
                sz = 16'($urandom_range(16'h1000, 16'hFFFF));
            else if (roll < 22)
                sz = 16'($urandom_range(65, 16'h0FFF));
            else
                sz = 16'($urandom_range(4, 64));
            send_size(sz);
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
